### rtl/irs_pkg.sv
package irs_pkg;

  // command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // filter modes
  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  // register indexes
  localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_STEP_X        = 3'd2;
  localparam logic [2:0] REG_STEP_Y        = 3'd3;
  localparam logic [2:0] REG_FILTER_MODE   = 3'd4;

  // fixed point
  localparam int          FRAC_BITS = 17;
  localparam logic [17:0] ONE_Q17   = 18'd131072;
  localparam int          ROUND_POS = 33;
  localparam int          SUM_SHIFT = 34;

  // result queue
  localparam int OUT_DEPTH = 16;
  localparam int OUT_PTR_W = 4;
  localparam int OUT_CNT_W = 5;

  typedef struct packed {
    logic       command;
    logic [9:0] column;
    logic [9:0] row;
    logic [1:0] channel;
    logic [7:0] pixel_in;
  } irs_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       status;
  } irs_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [23:0] data;
  } irs_cfg_t;

  typedef struct packed {
    logic [7:0]  source_width;
    logic [7:0]  source_height;
    logic [23:0] step_x;
    logic [23:0] step_y;
    logic        filter_mode;
  } irs_regs_t;

  typedef struct packed {
    logic        store;
    logic        bad;
    logic        bilinear;
    logic [9:0]  x0;
    logic [9:0]  x1;
    logic [9:0]  y0;
    logic [9:0]  y1;
    logic [1:0]  ch;
    logic [16:0] ax;
    logic [16:0] ay;
    logic [7:0]  pix;
  } irs_item_t;

  typedef struct packed {
    logic        valid;
    logic        direct;
    logic        store;
    logic        status;
    logic [1:0]  k;
    logic [16:0] ax;
    logic [16:0] ay;
  } irs_tag_t;

  // clamp a signed coordinate to [0, lim-1]
  function automatic logic [9:0] clamp_coord(logic signed [19:0] v, logic [10:0] lim);
    logic signed [20:0] hi;
    logic [10:0]        lm1;
    hi  = $signed({10'd0, lim}) - 21'sd1;
    lm1 = lim - 11'd1;
    if (v < 20'sd0) begin
      return 10'd0;
    end else if ($signed({v[19], v}) > hi) begin
      return lm1[9:0];
    end
    return v[9:0];
  endfunction

endpackage

### rtl/irs_stream_if.sv
interface irs_stream_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     payload;

  modport source (input clk, output valid, output payload, input ready);
  modport sink   (input clk, input valid, input payload, output ready);
endinterface

### rtl/image_resize_sampler.sv
// Image resize sampler: bilinear / nearest scaler over a stored source frame.
// Channels (valid/ready, a beat moves when both are high):
//   cfg : register writes, index + data; always ready. Write only while idle.
//   req : command beats. Store writes one source pixel; read samples the
//         resized image at a destination column and row.
//   rsp : exactly one result beat per request beat, in request order.
// The single frame memory port is held by a bilinear read for its four
//   neighbor fetches; a store or a nearest read needs one memory access.
//   The sequencer takes the next item as it issues the last memory beat.
// Requests flow through two coordinate stages (multiply, then floor and
// clamp), a sequencer issuing memory beats, and a blend pipeline.
// A 16-entry result queue decouples rsp: a credit counter stops the
// sequencer when the queue plus in-flight items would overflow, so a
// stalled receiver only backs up req, never loses a result.
// Reset clears control state and loads register defaults (128x128 frame,
// unity steps, bilinear). Frame contents are not cleared.
module image_resize_sampler #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int CHANNELS = 4,
  parameter int PIXEL_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  irs_stream_if.sink   cfg,
  irs_stream_if.sink   req,
  irs_stream_if.source rsp
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int ADDR_W = $clog2(DEPTH);

  irs_pkg::irs_regs_t regs;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.source_width  <= 8'd128;
      regs.source_height <= 8'd128;
      regs.step_x        <= 24'd65536;
      regs.step_y        <= 24'd65536;
      regs.filter_mode   <= irs_pkg::MODE_BILINEAR;
    end else if (cfg.valid) begin
      unique case (cfg.payload.index)
        irs_pkg::REG_SOURCE_WIDTH:  regs.source_width  <= cfg.payload.data[7:0];
        irs_pkg::REG_SOURCE_HEIGHT: regs.source_height <= cfg.payload.data[7:0];
        irs_pkg::REG_STEP_X:        regs.step_x        <= cfg.payload.data;
        irs_pkg::REG_STEP_Y:        regs.step_y        <= cfg.payload.data;
        irs_pkg::REG_FILTER_MODE:   regs.filter_mode   <= cfg.payload.data[0];
        default: ;
      endcase
    end
  end

  // coordinate front end
  logic               item_valid, take, credit_ok;
  irs_pkg::irs_item_t item;

  irs_coord #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CHANNELS(CHANNELS)
  ) u_coord (
    .clk(clk), .rst(rst), .req(req), .regs(regs), .take(take),
    .item_valid(item_valid), .item(item)
  );

  // memory beat sequencer
  logic                  mem_en, mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [PIXEL_BITS-1:0] mem_wdata, mem_rdata;
  irs_pkg::irs_tag_t     tag;

  irs_seq #(
    .MAX_WIDTH(MAX_WIDTH), .CHANNELS(CHANNELS), .ADDR_W(ADDR_W), .PW(PIXEL_BITS)
  ) u_seq (
    .clk(clk), .rst(rst), .item_valid(item_valid), .item(item),
    .credit_ok(credit_ok), .take(take), .mem_en(mem_en), .mem_we(mem_we),
    .mem_addr(mem_addr), .mem_wdata(mem_wdata), .tag(tag)
  );

  irs_frame #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .PW(PIXEL_BITS)) u_frame (
    .clk(clk), .en(mem_en), .we(mem_we), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata)
  );

  logic              res_valid;
  irs_pkg::irs_out_t res;

  irs_blend #(.PW(PIXEL_BITS)) u_blend (
    .clk(clk), .rst(rst), .tag(tag), .rdata(mem_rdata),
    .res_valid(res_valid), .res(res)
  );

  // result queue and credits
  irs_pkg::irs_out_t               fifo [irs_pkg::OUT_DEPTH];
  logic [irs_pkg::OUT_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [irs_pkg::OUT_CNT_W-1:0]   fifo_cnt, credit_cnt;
  logic                            pop;

  assign pop = rsp.valid && rsp.ready;
  assign rsp.valid = (fifo_cnt != '0);
  assign rsp.payload = fifo[rd_ptr];
  assign credit_ok = (credit_cnt < irs_pkg::OUT_CNT_W'(irs_pkg::OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fifo_cnt <= '0;
      credit_cnt <= '0;
    end else begin
      if (res_valid) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fifo_cnt <= fifo_cnt + irs_pkg::OUT_CNT_W'(res_valid) - irs_pkg::OUT_CNT_W'(pop);
      credit_cnt <= credit_cnt + irs_pkg::OUT_CNT_W'(take) - irs_pkg::OUT_CNT_W'(pop);
    end
    if (res_valid) fifo[wr_ptr] <= res;
  end

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    credit_cnt <= irs_pkg::OUT_CNT_W'(irs_pkg::OUT_DEPTH))
    else $error("credit counter overrun");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> fifo_cnt < irs_pkg::OUT_CNT_W'(irs_pkg::OUT_DEPTH))
    else $error("result pushed into full queue");

  a_queue_covered: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= credit_cnt)
    else $error("queued results exceed outstanding credits");

endmodule

### rtl/irs_frame.sv
module irs_frame #(
  parameter int DEPTH = 65536,
  parameter int ADDR_W = 16,
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [PW-1:0]     wdata,
  output logic [PW-1:0]     rdata
);

  logic [PW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

### rtl/irs_coord.sv
module irs_coord #(
  parameter int MAX_WIDTH = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int CHANNELS = 4
) (
  input  logic                clk,
  input  logic                rst,
  irs_stream_if.sink          req,
  input  irs_pkg::irs_regs_t  regs,
  input  logic                take,
  output logic                item_valid,
  output irs_pkg::irs_item_t  item
);

  logic               v1;
  irs_pkg::irs_in_t   s1;
  logic [34:0]        px, py;
  logic               en1, en2;

  logic [10:0]        w_eff, h_eff;
  logic signed [35:0] qx, qy;
  logic signed [19:0] fx, fy, fx1, fy1, rx, ry;
  logic               bad;
  logic [1:0]         ch_rd;
  irs_pkg::irs_item_t item_next;

  assign en2 = !item_valid || take;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  always_comb begin
    if (regs.source_width == 8'd0) w_eff = 11'd1;
    else if ({3'd0, regs.source_width} > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    else w_eff = {3'd0, regs.source_width};
    if (regs.source_height == 8'd0) h_eff = 11'd1;
    else if ({3'd0, regs.source_height} > 11'(MAX_HEIGHT)) h_eff = 11'(MAX_HEIGHT);
    else h_eff = {3'd0, regs.source_height};
  end

  always_comb begin
    qx  = $signed({1'b0, px}) - 36'sd65536;
    qy  = $signed({1'b0, py}) - 36'sd65536;
    fx  = {qx[35], qx[35:17]};
    fy  = {qy[35], qy[35:17]};
    fx1 = fx + 20'sd1;
    fy1 = fy + 20'sd1;
    // round half away: negatives all land on column or row zero after clamping
    rx  = $signed({2'b00, px[34:17]});
    ry  = $signed({2'b00, py[34:17]});
    bad = ({1'b0, s1.column} >= w_eff) || ({1'b0, s1.row} >= h_eff) ||
          (32'(s1.channel) >= 32'(CHANNELS));
    ch_rd = (32'(s1.channel) >= 32'(CHANNELS)) ? 2'(CHANNELS - 1) : s1.channel;

    item_next          = '0;
    item_next.store    = (s1.command == irs_pkg::CMD_STORE);
    item_next.bad      = bad;
    item_next.bilinear = (regs.filter_mode == irs_pkg::MODE_BILINEAR);
    item_next.pix      = s1.pixel_in;
    item_next.ax       = qx[16:0];
    item_next.ay       = qy[16:0];
    if (s1.command == irs_pkg::CMD_STORE) begin
      item_next.x0 = s1.column;
      item_next.x1 = s1.column;
      item_next.y0 = s1.row;
      item_next.y1 = s1.row;
      item_next.ch = s1.channel;
    end else if (regs.filter_mode == irs_pkg::MODE_BILINEAR) begin
      item_next.x0 = irs_pkg::clamp_coord(fx, w_eff);
      item_next.x1 = irs_pkg::clamp_coord(fx1, w_eff);
      item_next.y0 = irs_pkg::clamp_coord(fy, h_eff);
      item_next.y1 = irs_pkg::clamp_coord(fy1, h_eff);
      item_next.ch = ch_rd;
    end else begin
      item_next.x0 = irs_pkg::clamp_coord(rx, w_eff);
      item_next.x1 = item_next.x0;
      item_next.y0 = irs_pkg::clamp_coord(ry, h_eff);
      item_next.y1 = item_next.y0;
      item_next.ch = ch_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      item_valid <= 1'b0;
    end else begin
      if (en1) v1 <= req.valid;
      if (en2) item_valid <= v1;
    end
    if (en1 && req.valid) begin
      s1 <= req.payload;
      px <= 35'({req.payload.column, 1'b1}) * 35'(regs.step_x);
      py <= 35'({req.payload.row, 1'b1}) * 35'(regs.step_y);
    end
    if (en2 && v1) item <= item_next;
  end

endmodule

### rtl/irs_seq.sv
module irs_seq #(
  parameter int MAX_WIDTH = 128,
  parameter int CHANNELS = 4,
  parameter int ADDR_W = 16,
  parameter int PW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  irs_pkg::irs_item_t item,
  input  logic               credit_ok,
  output logic               take,
  output logic               mem_en,
  output logic               mem_we,
  output logic [ADDR_W-1:0]  mem_addr,
  output logic [PW-1:0]      mem_wdata,
  output irs_pkg::irs_tag_t  tag
);

  logic               active;
  logic [1:0]         k;
  irs_pkg::irs_item_t itm;
  logic               last_beat;
  logic [9:0]         bx, by;

  assign last_beat = itm.store || !itm.bilinear || (k == 2'd3);
  assign take = item_valid && credit_ok && (!active || last_beat);

  always_comb begin
    bx = k[0] ? itm.x1 : itm.x0;
    by = k[1] ? itm.y1 : itm.y0;
    mem_addr  = ADDR_W'((32'(by) * 32'(MAX_WIDTH) + 32'(bx)) * 32'(CHANNELS) + 32'(itm.ch));
    mem_en    = active && !(itm.store && itm.bad);
    mem_we    = itm.store;
    mem_wdata = PW'(itm.pix);
    tag.valid  = active;
    tag.direct = itm.store || !itm.bilinear;
    tag.store  = itm.store;
    tag.status = itm.store && itm.bad;
    tag.k      = k;
    tag.ax     = itm.ax;
    tag.ay     = itm.ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k <= 2'd0;
    end else if (take) begin
      active <= 1'b1;
      k <= 2'd0;
    end else if (active && last_beat) begin
      active <= 1'b0;
    end else if (active) begin
      k <= k + 2'd1;
    end
    if (take) itm <= item;
  end

endmodule

### rtl/irs_blend.sv
module irs_blend #(
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  irs_pkg::irs_tag_t tag,
  input  logic [PW-1:0]     rdata,
  output logic              res_valid,
  output irs_pkg::irs_out_t res
);

  localparam int P1_W = PW + 18;
  localparam int P3_W = PW + 36;
  localparam int RND_W = P3_W - irs_pkg::SUM_SHIFT;
  localparam logic [PW-1:0] PMAX = {PW{1'b1}};

  irs_pkg::irs_tag_t t0, t1, t2, t3;
  logic [PW-1:0]   val0;
  logic [17:0]     wx, wy;
  logic [P1_W-1:0] p1, rowacc, row2;
  logic [P3_W-1:0] p3, acc, sum;
  logic [RND_W-1:0] rnd;
  logic [PW-1:0]   sat;

  always_comb begin
    val0 = t0.store ? '0 : rdata;
    wx = t0.k[0] ? {1'b0, t0.ax} : (irs_pkg::ONE_Q17 - {1'b0, t0.ax});
    wy = t2.k[1] ? {1'b0, t2.ay} : (irs_pkg::ONE_Q17 - {1'b0, t2.ay});
    sum = acc + p3 + (P3_W'(1) << irs_pkg::ROUND_POS);
    rnd = sum[P3_W-1:irs_pkg::SUM_SHIFT];
    sat = (rnd > RND_W'(PMAX)) ? PMAX : rnd[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0.valid <= 1'b0;
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      t0.valid <= tag.valid;
      t1.valid <= t0.valid;
      t2.valid <= t1.valid && (t1.direct || t1.k[0]);
      t3.valid <= t2.valid;
      res_valid <= t3.valid && (t3.direct || t3.k[1]);
    end
    {t0.direct, t0.store, t0.status, t0.k, t0.ax, t0.ay} <=
      {tag.direct, tag.store, tag.status, tag.k, tag.ax, tag.ay};
    {t1.direct, t1.store, t1.status, t1.k, t1.ax, t1.ay} <=
      {t0.direct, t0.store, t0.status, t0.k, t0.ax, t0.ay};
    {t2.direct, t2.store, t2.status, t2.k, t2.ax, t2.ay} <=
      {t1.direct, t1.store, t1.status, t1.k, t1.ax, t1.ay};
    {t3.direct, t3.store, t3.status, t3.k, t3.ax, t3.ay} <=
      {t2.direct, t2.store, t2.status, t2.k, t2.ax, t2.ay};

    // horizontal weight
    p1 <= t0.direct ? P1_W'(val0) : P1_W'(val0) * P1_W'(wx);
    // pair up the two samples of a row
    if (t1.valid && !t1.direct && !t1.k[0]) rowacc <= p1;
    row2 <= t1.direct ? p1 : rowacc + p1;
    // vertical weight
    p3 <= t2.direct ? P3_W'(row2) : P3_W'(row2) * P3_W'(wy);
    if (t3.valid && !t3.direct && !t3.k[1]) acc <= p3;
    res.pixel_out <= t3.direct ? p3[7:0] : sat[7:0];
    res.status <= t3.status;
  end

endmodule

### test/image_resize_sampler_checker.sv
`timescale 1ns / 100ps

module image_resize_sampler_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  irs_pkg::irs_cfg_t cfg_beat,
  input  logic              req_valid,
  input  logic              req_ready,
  input  irs_pkg::irs_in_t  req_beat,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  irs_pkg::irs_out_t rsp_beat,
  output int                pending,
  output int                fail_count
);

  localparam int FRAME_W = 128;
  localparam int FRAME_H = 128;
  localparam int NUM_CH  = 4;

  logic [7:0]        frame_mem [FRAME_W*FRAME_H*NUM_CH];
  logic [7:0]        width_reg;
  logic [7:0]        height_reg;
  logic [23:0]       step_x_reg;
  logic [23:0]       step_y_reg;
  logic              mode_reg;
  irs_pkg::irs_out_t expected_pixels [$];

  assign pending = expected_pixels.size();

  function automatic int eff_size(logic [7:0] r, int max_size);
    if (r == 0) return 1;
    if (r > max_size) return max_size;
    return r;
  endfunction

  function automatic longint clamp(longint v, int lim);
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  function automatic longint round_away(longint q);
    if (q >= 0) return (q + 65536) >>> 17;
    return -((-q + 65536) >>> 17);
  endfunction

  function automatic longint fetch_px(longint x, longint y, int ch, int w, int h);
    return frame_mem[((clamp(y, h) * FRAME_W) + clamp(x, w)) * NUM_CH + ch];
  endfunction

  // predicts one result; stores update the frame copy
  function automatic irs_pkg::irs_out_t resample(irs_pkg::irs_in_t it);
    irs_pkg::irs_out_t r;
    int w, h, ch;
    longint qx, qy, fx, fy, ax, ay, bx, by, acc, v;
    r = '0;
    w = eff_size(width_reg, FRAME_W);
    h = eff_size(height_reg, FRAME_H);
    ch = it.channel;
    if (it.command == irs_pkg::CMD_STORE) begin
      if (it.column >= w || it.row >= h) begin
        r.status = 1'b1;
      end else begin
        frame_mem[((it.row * FRAME_W) + it.column) * NUM_CH + ch] = it.pixel_in;
      end
      return r;
    end
    qx = longint'(2 * it.column + 1) * longint'(step_x_reg) - 65536;
    qy = longint'(2 * it.row + 1) * longint'(step_y_reg) - 65536;
    if (mode_reg == irs_pkg::MODE_NEAREST) begin
      r.pixel_out = fetch_px(round_away(qx), round_away(qy), ch, w, h);
      return r;
    end
    fx = qx >>> 17;  // arithmetic shift is floor
    fy = qy >>> 17;
    ax = qx - fx * 131072;
    ay = qy - fy * 131072;
    bx = 131072 - ax;
    by = 131072 - ay;
    acc = fetch_px(fx, fy, ch, w, h) * bx * by
        + fetch_px(fx + 1, fy, ch, w, h) * ax * by
        + fetch_px(fx, fy + 1, ch, w, h) * bx * ay
        + fetch_px(fx + 1, fy + 1, ch, w, h) * ax * ay;
    v = (acc + (longint'(1) << 33)) >>> 34;
    r.pixel_out = (v > 255) ? 8'd255 : v[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    irs_pkg::irs_out_t want;
    if (rst) begin
      width_reg  <= 8'd128;
      height_reg <= 8'd128;
      step_x_reg <= 24'd65536;
      step_y_reg <= 24'd65536;
      mode_reg   <= irs_pkg::MODE_BILINEAR;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_beat.index)
          irs_pkg::REG_SOURCE_WIDTH:  width_reg  <= cfg_beat.data[7:0];
          irs_pkg::REG_SOURCE_HEIGHT: height_reg <= cfg_beat.data[7:0];
          irs_pkg::REG_STEP_X:        step_x_reg <= cfg_beat.data;
          irs_pkg::REG_STEP_Y:        step_y_reg <= cfg_beat.data;
          irs_pkg::REG_FILTER_MODE:   mode_reg   <= cfg_beat.data[0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, rsp_beat);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_pixels.pop_front();
          if (want.pixel_out !== rsp_beat.pixel_out || want.status !== rsp_beat.status) begin
            $display("%0t: mismatch pixel_out exp %0d got %0d, status exp %0d got %0d",
                     $time, want.pixel_out, rsp_beat.pixel_out, want.status,
                     rsp_beat.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      // config writes happen only while idle, so req sees settled registers
      if (req_valid && req_ready) expected_pixels.push_back(resample(req_beat));
    end
  end

endmodule

### test/image_resize_sampler_tb.sv
`timescale 1ns / 100ps

module image_resize_sampler_tb;

  logic clk;
  logic rst;
  int   pending;
  int   fail_count;
  int   rsp_beats;

  irs_stream_if #(.T(irs_pkg::irs_cfg_t)) cfg_ch (clk);
  irs_stream_if #(.T(irs_pkg::irs_in_t))  req_ch (clk);
  irs_stream_if #(.T(irs_pkg::irs_out_t)) rsp_ch (clk);

  image_resize_sampler dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch.sink),
    .req(req_ch.sink),
    .rsp(rsp_ch.source)
  );

  image_resize_sampler_checker checker_i (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_beat(cfg_ch.payload),
    .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_beat(req_ch.payload),
    .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_beat(rsp_ch.payload),
    .pending(pending), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop; far beyond the slowest legal run
  initial begin
    #5000000;
    $display("image_resize_sampler regression: fail");
    $finish;
  end

  // Result side: random stall per beat, plus one long hold-off once
  // a few hundred beats are through, so the result queue fills and req backs up.
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    rsp_beats = 0;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
      if (rsp_beats == 300) gap = 400;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      rsp_beats++;
    end
  end

  // One register write; caller makes sure the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // One request beat followed by a random sender gap.
  // valid stays high across back-to-back beats.
  task automatic send(logic cmd, logic [9:0] col, logic [9:0] row, logic [1:0] ch,
                      logic [7:0] pix);
    int gap;
    req_ch.valid   <= 1'b1;
    req_ch.payload <= '{command: cmd, column: col, row: row, channel: ch, pixel_in: pix};
    do @(posedge clk); while (!req_ch.ready);
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain, then let a store-free tail of the pipeline settle before writes.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (16) @(posedge clk);
  endtask

  // A phase: program all registers, write the fill region on every channel
  // so reads never touch an unwritten pixel, then a random mix.
  // Reads draw destination coordinates up to max_d.
  task automatic run_phase(logic [7:0] w, logic [7:0] h, logic [23:0] sx,
                           logic [23:0] sy, logic mode, int fill_w, int fill_h,
                           int max_d, int n_items);
    int pick;
    wait_idle();
    write_reg(irs_pkg::REG_SOURCE_WIDTH, w);
    write_reg(irs_pkg::REG_SOURCE_HEIGHT, h);
    write_reg(irs_pkg::REG_STEP_X, sx);
    write_reg(irs_pkg::REG_STEP_Y, sy);
    write_reg(irs_pkg::REG_FILTER_MODE, mode);
    for (int r = 0; r < fill_h; r++)
      for (int c = 0; c < fill_w; c++)
        for (int k = 0; k < 4; k++)
          send(irs_pkg::CMD_STORE, c, r, k, $urandom_range(255));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        send(irs_pkg::CMD_READ, $urandom_range(max_d), $urandom_range(max_d),
             $urandom_range(3), $urandom_range(255));
      end else if (pick < 85 && fill_w > 0) begin
        send(irs_pkg::CMD_STORE, $urandom_range(fill_w - 1), $urandom_range(fill_h - 1),
             $urandom_range(3), $urandom_range(255));
      end else begin
        // noise store: anywhere, mostly dropped
        send(irs_pkg::CMD_STORE, $urandom_range(1023), $urandom_range(1023),
             $urandom_range(3), $urandom_range(255));
      end
    end
  endtask

  initial begin
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, at reset defaults (128x128, unity step, bilinear).
    // Fill the 8x8 corner; later phases lean on it for the full-size frame.
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        for (int k = 0; k < 4; k++)
          send(irs_pkg::CMD_STORE, c, r, k, $urandom_range(255));
    send(irs_pkg::CMD_STORE, 0, 0, 0, 8'h00);
    send(irs_pkg::CMD_STORE, 7, 7, 3, 8'hff);
    send(irs_pkg::CMD_STORE, 6, 6, 3, 8'hff);
    send(irs_pkg::CMD_STORE, 10'd128, 0, 0, 8'h55);     // just past the width: dropped
    send(irs_pkg::CMD_STORE, 0, 10'd128, 1, 8'haa);     // just past the height: dropped
    send(irs_pkg::CMD_STORE, 10'd1023, 10'd1023, 3, 8'hff);
    send(irs_pkg::CMD_READ, 0, 0, 0, 8'hff);
    send(irs_pkg::CMD_READ, 6, 6, 3, 8'h00);
    send(irs_pkg::CMD_READ, 5, 6, 2, 8'h00);

    // defaults, reads kept inside the filled corner
    run_phase(8'd128, 8'd128, 24'd65536, 24'd65536, irs_pkg::MODE_BILINEAR,
              0, 0, 6, 80);
    // smallest frame, large step, nearest
    run_phase(8'd1, 8'd1, 24'h800000, 24'h800000, irs_pkg::MODE_NEAREST,
              1, 1, 1023, 80);
    // odd size, fractional steps
    run_phase(8'd5, 8'd3, 24'd37449, 24'd28086, irs_pkg::MODE_BILINEAR,
              5, 3, 1023, 150);
    // width 0 acts as 1, height above max acts as 128, zero x step
    run_phase(8'd0, 8'd200, 24'd0, 24'd1, irs_pkg::MODE_NEAREST, 1, 1, 1023, 80);
    // full frame, tiny steps keep every neighbor inside the filled corner
    run_phase(8'd128, 8'd128, 24'd300, 24'd257, irs_pkg::MODE_BILINEAR,
              0, 0, 1023, 80);
    // random steps each phase end
    run_phase(8'd7, 8'd6, $urandom_range(24'h800000, 1), $urandom_range(24'h800000, 1),
              irs_pkg::MODE_BILINEAR, 7, 6, 1023, 80);
    run_phase(8'd7, 8'd6, $urandom_range(24'h30000, 1), $urandom_range(24'h30000, 1),
              irs_pkg::MODE_NEAREST, 0, 0, 1023, 60);

    wait_idle();
    if (fail_count == 0) begin
      $display("image_resize_sampler regression: pass");
    end else begin
      $display("image_resize_sampler regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/irs_pkg.sv
rtl/irs_stream_if.sv
rtl/irs_frame.sv
rtl/irs_coord.sv
rtl/irs_seq.sv
rtl/irs_blend.sv
rtl/image_resize_sampler.sv
test/image_resize_sampler_checker.sv
test/image_resize_sampler_tb.sv
